FILE: rtl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// Types, codes and constants shared by the +IPD frame extractor.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // saturation limit of the decimal frame length
  localparam int unsigned MaxLength  = 2000;
  localparam int unsigned LenW       = 11;
  // wide enough for length * 10 + 9 before saturation
  localparam int unsigned LenCalcW   = 15;
  localparam int unsigned PrefixLen  = 5;
  localparam int unsigned PrefixIdxW = 3;

  // input item modes
  localparam logic [1:0] ModeByte    = 2'd0;
  localparam logic [1:0] ModeOverrun = 2'd1;
  localparam logic [1:0] ModeClear   = 2'd2;

  // result routes
  localparam logic [1:0] RouteText    = 2'd0;
  localparam logic [1:0] RouteHeader  = 2'd1;
  localparam logic [1:0] RoutePayload = 2'd2;
  localparam logic [1:0] RouteNone    = 2'd3;

  // characters
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PhSearch  = 3'b001,
    PhLength  = 3'b010,
    PhPayload = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      route;
    logic [7:0]      data_byte;
    logic            frame_end;
    logic [LenW-1:0] frame_length;
  } out_req_t;

  // expected character of "+IPD," at a match position
  function automatic logic [7:0] prefix_char(input logic [PrefixIdxW-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B; // '+'
      3'd1:    c = 8'h49; // 'I'
      3'd2:    c = 8'h50; // 'P'
      3'd3:    c = 8'h44; // 'D'
      3'd4:    c = 8'h2C; // ','
      default: c = 8'h2B;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/ipd_frame_extractor.sv
// ----------------------------------------------------------------------------
// ipd_frame_extractor
// Splits +IPD,<length>:<payload> frames out of a received UART byte stream.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid_i / in_stall_o / in_req_i carries one request per
//   cycle: a received byte, a receiver overrun event or a parser clear
// - output channel out_valid_o / out_stall_i / out_req_o returns exactly one
//   request per input: the byte tagged as text, header or payload, the last
//   payload byte flagged, and the parsed (saturated) frame length
// - the parser state and the result register update at the edge that accepts
//   the input, and the result is valid after it
// - throughput is one item per cycle while the receiver does not stall; the
//   parse step is a small state update feeding the result register directly
// - when the receiver stalls, the result register holds; a new input is still
//   taken in the cycle in which the held result is taken, otherwise
//   in_stall_o is raised until the result drains
// - reset (rst_ni low, asynchronous) clears the parser to prefix search and
//   empties the result register; no clearing pass is needed
// ----------------------------------------------------------------------------
module ipd_frame_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ipd_pkg::in_req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipd_pkg::out_req_t  out_req_o
);
  import ipd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [PrefixIdxW-1:0] pidx_q, pidx_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [LenW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q;
  out_req_t              out_q, res;
  logic                  in_fire;
  logic [PrefixIdxW-1:0] idx;
  logic [PrefixIdxW-1:0] idx_inc;
  logic [LenCalcW-1:0]   len_calc;
  logic [LenW-1:0]       cnt_inc;
  logic                  is_digit;

  // handshake: take a request whenever the result register is free or drains
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // datapath helpers
  assign idx      = (pidx_q >= PrefixIdxW'(PrefixLen)) ? '0 : pidx_q;
  assign idx_inc  = idx + 1'b1;
  assign is_digit = (in_req_i.rx_byte >= CharZero) && (in_req_i.rx_byte <= CharNine);
  assign len_calc = ({{(LenCalcW-LenW){1'b0}}, len_q} << 3)
                  + ({{(LenCalcW-LenW){1'b0}}, len_q} << 1)
                  + LenCalcW'(in_req_i.rx_byte - CharZero);
  assign cnt_inc  = cnt_q + 1'b1;

  // parse step
  always_comb begin
    phase_d          = phase_q;
    pidx_d           = pidx_q;
    len_d            = len_q;
    cnt_d            = cnt_q;
    res.route        = RouteNone;
    res.data_byte    = in_req_i.rx_byte;
    res.frame_end    = 1'b0;
    res.frame_length = '0;

    if (in_req_i.mode == ModeClear) begin
      phase_d = PhSearch;
      pidx_d  = '0;
      len_d   = '0;
      cnt_d   = '0;
    end else if (in_req_i.mode == ModeByte) begin
      unique case (phase_q)
        PhSearch: begin
          if (in_req_i.rx_byte == prefix_char(idx)) begin
            res.route = RouteHeader;
            if (idx_inc >= PrefixIdxW'(PrefixLen)) begin
              phase_d = PhLength;
              pidx_d  = '0;
              len_d   = '0;
            end else begin
              pidx_d = idx_inc;
            end
          end else if (in_req_i.rx_byte == CharPlus) begin
            // stray plus restarts the match after its first character
            res.route = RouteHeader;
            pidx_d    = PrefixIdxW'(1);
          end else begin
            res.route = RouteText;
            pidx_d    = '0;
          end
        end
        PhLength: begin
          res.route = RouteHeader;
          if (is_digit) begin
            len_d = (len_calc > LenCalcW'(MaxLength)) ? LenW'(MaxLength)
                                                     : len_calc[LenW-1:0];
          end else if (in_req_i.rx_byte == CharColon) begin
            phase_d = PhPayload;
            cnt_d   = '0;
          end else begin
            // bad length character aborts the frame
            phase_d = PhSearch;
            pidx_d  = '0;
          end
        end
        PhPayload: begin
          res.route = RoutePayload;
          cnt_d     = cnt_inc;
          if (cnt_inc >= len_q) begin
            res.frame_end = 1'b1;
            phase_d       = PhSearch;
            pidx_d        = '0;
          end
        end
        default: begin
          res.route = RouteText;
        end
      endcase
    end

    if (res.route == RouteNone) begin
      res.data_byte = '0;
    end
    if (res.route == RouteHeader || res.route == RoutePayload) begin
      res.frame_length = len_d;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      pidx_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      pidx_q  <= pidx_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

endmodule

FILE: tb/ipd_frame_extractor_tb.sv
// ----------------------------------------------------------------------------
// ipd_frame_extractor_tb
// Feeds the +IPD frame extractor with a directed run of byte sequences and
// then mostly well-formed frames mixed with broken prefixes, bad and
// saturating lengths, overruns, clears and noise. A local parser model
// predicts the tag of every byte, and each result is compared with it field
// by field. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module ipd_frame_extractor_tb;
  import ipd_pkg::*;

  // mode with no function; the block returns it untagged and leaves its parser as is
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned HoldCycles = 80;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  ipd_frame_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // clock and reset
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // parser model state
  logic [7:0]  ipd_chars [PrefixLen] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
  phase_e      parse_ph = PhSearch;
  int unsigned match_idx = 0;
  int unsigned len_need = 0;
  int unsigned pay_cnt = 0;

  in_req_t     rx_q[$];
  out_req_t    routed_q[$];
  int unsigned err_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  out_req_t    want;

  // tag one request and advance the parser model
  function automatic out_req_t route_byte(input in_req_t req);
    out_req_t    r;
    int unsigned idx;
    int unsigned v;
    r = '0;
    r.route = RouteNone;
    if (req.mode == ModeClear) begin
      parse_ph = PhSearch;
      match_idx = 0;
      len_need = 0;
      pay_cnt = 0;
    end else if (req.mode == ModeByte) begin
      r.data_byte = req.rx_byte;
      case (parse_ph)
        PhSearch: begin
          idx = (match_idx >= PrefixLen) ? 0 : match_idx;
          if (req.rx_byte == ipd_chars[idx]) begin
            r.route = RouteHeader;
            idx++;
            if (idx >= PrefixLen) begin
              parse_ph = PhLength;
              idx = 0;
              len_need = 0;
            end
          end else if (req.rx_byte == CharPlus) begin
            // a plus breaking a partial match starts a new one
            r.route = RouteHeader;
            idx = 1;
          end else begin
            r.route = RouteText;
            idx = 0;
          end
          match_idx = idx;
        end
        PhLength: begin
          r.route = RouteHeader;
          if (req.rx_byte >= CharZero && req.rx_byte <= CharNine) begin
            v = len_need * 10 + (req.rx_byte - CharZero);
            len_need = (v > MaxLength) ? MaxLength : v;
          end else if (req.rx_byte == CharColon) begin
            parse_ph = PhPayload;
            pay_cnt = 0;
          end else begin
            // bad length character aborts the frame
            parse_ph = PhSearch;
            match_idx = 0;
          end
        end
        PhPayload: begin
          r.route = RoutePayload;
          pay_cnt++;
          if (pay_cnt >= len_need) begin
            r.frame_end = 1'b1;
            parse_ph = PhSearch;
            match_idx = 0;
          end
        end
        default: r.route = RouteText;
      endcase
    end
    if (r.route == RouteHeader || r.route == RoutePayload) r.frame_length = len_need[LenW-1:0];
    return r;
  endfunction

  task automatic push_item(input logic [1:0] mode, input logic [7:0] b);
    in_req_t req;
    req.mode = mode;
    req.rx_byte = b;
    rx_q.push_back(req);
  endtask

  task automatic push_text(input string s);
    int unsigned i;
    for (i = 0; i < s.len(); i++) push_item(ModeByte, s[i]);
  endtask

  task automatic push_bad_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CharZero && b <= CharNine) || b == CharColon);
    push_item(ModeByte, b);
  endtask

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    err_cnt++;
    // keep the log readable if the block is badly off
    if (err_cnt <= 100)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
  endtask

  // driver: offers queued requests, idles at random outside a quiet window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        routed_q.push_back(route_byte(in_req_i));
        acc_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_q.size() != 0 &&
            !((acc_cnt < 500 || acc_cnt >= 800) && $urandom_range(99) < 7)) begin
          in_valid_i <= 1'b1;
          in_req_i <= rx_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (routed_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_req_o);
        end else begin
          want = routed_q.pop_front();
          if (out_req_o.route !== want.route)
            report_field("route", 16'(want.route), 16'(out_req_o.route));
          if (out_req_o.data_byte !== want.data_byte)
            report_field("data_byte", 16'(want.data_byte), 16'(out_req_o.data_byte));
          if (out_req_o.frame_end !== want.frame_end)
            report_field("frame_end", 16'(want.frame_end), 16'(out_req_o.frame_end));
          if (out_req_o.frame_length !== want.frame_length)
            report_field("frame_length", 16'(want.frame_length),
                         16'(out_req_o.frame_length));
        end
        res_cnt++;
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && res_cnt >= 300) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (res_cnt < 500 || res_cnt >= 800) && ($urandom_range(99) < 7);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned flen;
    int unsigned n;
    int unsigned i;
    string       s;

    // directed: partial prefix, stray plus with zero length, saturating length
    // with overrun and unused mode inside, bad length character, clear
    push_text("+IPx");
    push_text("+I+IPD,0:z");
    push_text("+IPD,99999");
    push_item(ModeOverrun, 8'hFF);
    push_item(ModeUnused, 8'h00);
    push_text("q");
    push_item(ModeClear, 8'h5A);

    // random: mostly well-formed frames, some broken ones and noise
    while (rx_q.size() < 1380) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n = $urandom_range(3);
        for (i = 0; i < n; i++) push_item(ModeByte, 8'($urandom_range(255)));
        flen = ($urandom_range(9) == 0) ? $urandom_range(60, 16) : $urandom_range(12);
        s = $sformatf("+IPD,%s%0d:", ($urandom_range(7) == 0) ? "0" : "", flen);
        push_text(s);
        for (i = 0; i < ((flen == 0) ? 1 : flen); i++) begin
          if ($urandom_range(19) == 0)
            push_item($urandom_range(1) ? ModeOverrun : ModeUnused,
                      8'($urandom_range(255)));
          push_item(ModeByte, 8'($urandom_range(255)));
        end
      end else if (kind < 80) begin
        n = $urandom_range(2);
        if (n == 0) begin
          // prefix cut short by a random byte
          push_text(s.substr(0, 0));
          s = "+IPD,";
          rx_q.pop_back();
          push_text(s.substr(0, $urandom_range(3)));
          push_item(ModeByte, 8'($urandom_range(255)));
        end else if (n == 1) begin
          push_text($sformatf("+IPD,%0d", $urandom_range(99)));
          push_bad_char();
        end else begin
          push_text($sformatf("+IPD,%0d:", $urandom_range(20, 5)));
          for (i = 0; i < $urandom_range(4); i++)
            push_item(ModeByte, 8'($urandom_range(255)));
          push_item(ModeClear, 8'($urandom_range(255)));
        end
      end else if (kind < 88) begin
        // length beyond the limit, then aborted
        push_text($sformatf("+IPD,%0d", $urandom_range(99999, 2001)));
        if ($urandom_range(1)) push_bad_char();
        else push_item(ModeClear, 8'($urandom_range(255)));
      end else begin
        n = $urandom_range(8, 1);
        for (i = 0; i < n; i++) push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end

    wait (rst_ni);
    while (rx_q.size() != 0 || in_valid_i || routed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (routed_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results missing, expected %p, got none", $time,
               routed_q.size(), routed_q[0]);
    end
    if (err_cnt == 0) begin
      $display("ipd_frame_extractor_tb: done, clean");
    end else begin
      $display("ipd_frame_extractor_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("ipd_frame_extractor_tb: done, errors");
    $finish;
  end

endmodule
